[hw/rtl/llbg_pkg.sv]
// Shared types and constants for the linear layer backward gradient block.
// No dependencies; used by linear_layer_backward_gradients and the testbench.
package llbg_pkg;

  // Input command codes
  typedef enum logic [2:0] {
    CMD_LOAD_W  = 3'd0,
    CMD_LOAD_X  = 3'd1,
    CMD_GRAD    = 3'd2,
    CMD_ROW_END = 3'd3,
    CMD_RD_WG   = 3'd4,
    CMD_RD_BG   = 3'd5,
    CMD_CLEAR   = 3'd6,
    CMD_NONE    = 3'd7
  } cmd_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_IGRAD = 2'd0,
    KIND_WGRAD = 2'd1,
    KIND_BGRAD = 2'd2
  } kind_e;

  // Controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_B_RD,
    ST_B_WR,
    ST_GRAD,
    ST_DRAIN,
    ST_ROW_RD,
    ST_ROW_WAIT,
    ST_RD_ISSUE,
    ST_RD_WAIT
  } state_e;

  // Register indexes on the config port
  localparam logic [1:0] REG_IN_USE  = 2'd0;
  localparam logic [1:0] REG_OUT_USE = 2'd1;
  localparam logic [1:0] REG_BIAS_EN = 2'd2;

  localparam int unsigned VAL_W = 16;
  localparam int unsigned ACC_W = 48;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

endpackage

[hw/rtl/llbg_ram.sv]
// Simple dual-port RAM: one write port, one read port with registered read.
// No dependencies.
module llbg_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[hw/rtl/linear_layer_backward_gradients.sv]
// Linear layer backward pass: gradient accumulation over RAM-held stores.
// A gradient word runs one MAC per cycle for each in-use input through the weight-gradient
//   RAM port, after a bias read-modify-write when bias is enabled; no word is accepted until
//   the MAC pipeline drains. A row end emits one input-gradient word per in-use input.
// Reset: async active low; then a sweep over the MAX_OUT_CH*MAX_IN_CH addresses zeroes the
//   weight- and bias-gradient stores (no words accepted). A clear command repeats it.
// Uses llbg_pkg and llbg_ram.
module linear_layer_backward_gradients #(
  parameter int unsigned MAX_IN_CH  = 64,
  parameter int unsigned MAX_OUT_CH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // out_channel[9:0], in_channel[15:10], value[31:16]
  input  logic [2:0]  s_tuser,   // command[2:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // index[15:0], result_value[63:16]
  output logic [1:0]  m_tuser,   // kind[1:0]
  output logic        m_tlast,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned WDEPTH = MAX_IN_CH * MAX_OUT_CH;
  localparam int unsigned AW  = WDEPTH > 1 ? $clog2(WDEPTH) : 1;
  localparam int unsigned IW  = MAX_IN_CH > 1 ? $clog2(MAX_IN_CH) : 1;
  localparam int unsigned OW  = MAX_OUT_CH > 1 ? $clog2(MAX_OUT_CH) : 1;
  localparam int unsigned CW  = $clog2(MAX_IN_CH + 1);
  localparam int unsigned ACC = llbg_pkg::ACC_W;

  // saturating 48-bit add
  function automatic logic signed [ACC-1:0] sat_add(logic signed [ACC-1:0] a,
                                                   logic signed [ACC-1:0] b);
    logic signed [ACC:0] s;
    s = {a[ACC-1], a} + {b[ACC-1], b};
    if (s[ACC] != s[ACC-1]) begin
      sat_add = s[ACC] ? llbg_pkg::ACC_MIN : llbg_pkg::ACC_MAX;
    end else begin
      sat_add = s[ACC-1:0];
    end
  endfunction

  // input word fields
  logic [9:0]         in_o;
  logic [5:0]         in_i;
  logic signed [15:0] in_v;
  llbg_pkg::cmd_e     in_cmd;
  assign in_o   = s_tdata[9:0];
  assign in_i   = s_tdata[15:10];
  assign in_v   = s_tdata[31:16];
  assign in_cmd = llbg_pkg::cmd_e'(s_tuser);

  // config registers
  logic [6:0]  in_use_q;
  logic [10:0] out_use_q;
  logic        bias_en_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q  <= 7'd64;
      out_use_q <= 11'd256;
      bias_en_q <= 1'b1;
    end else if (cfg_we) begin
      case (paddr[3:2])
        llbg_pkg::REG_IN_USE:  in_use_q  <= pwdata[6:0];
        llbg_pkg::REG_OUT_USE: out_use_q <= pwdata[10:0];
        llbg_pkg::REG_BIAS_EN: bias_en_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      llbg_pkg::REG_IN_USE:  prdata = {25'd0, in_use_q};
      llbg_pkg::REG_OUT_USE: prdata = {21'd0, out_use_q};
      llbg_pkg::REG_BIAS_EN: prdata = {31'd0, bias_en_q};
      default:               prdata = 32'd0;
    endcase
  end

  // effective channel counts and range checks
  logic [CW-1:0] nc;
  logic          o_ok, i_ok;
  assign nc   = (int'(in_use_q) > MAX_IN_CH) ? CW'(MAX_IN_CH) : CW'(in_use_q);
  assign o_ok = (int'(in_o) < int'(out_use_q)) && (int'(in_o) < MAX_OUT_CH);
  assign i_ok = int'(in_i) < int'(nc);

  llbg_pkg::state_e state_q, state_d;
  logic             accept;
  assign s_tready = (state_q == llbg_pkg::ST_IDLE);
  assign accept   = s_tvalid & s_tready;

  // latched command
  logic [AW-1:0]        base_q, waddr_q;
  logic [OW-1:0]        oaddr_q;
  logic [15:0]          idx_q;
  logic signed [15:0]   v_q;
  logic                 ok_q;
  llbg_pkg::kind_e      kind_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      base_q  <= AW'(int'(in_o) * MAX_IN_CH);
      waddr_q <= AW'(int'(in_o) * MAX_IN_CH + int'(in_i));
      oaddr_q <= in_o[OW-1:0];
      v_q     <= in_v;
      if (in_cmd == llbg_pkg::CMD_RD_BG) begin
        idx_q  <= {6'd0, in_o};
        ok_q   <= o_ok;
        kind_q <= llbg_pkg::KIND_BGRAD;
      end else begin
        idx_q  <= 16'(int'(in_o) * MAX_IN_CH + int'(in_i));
        ok_q   <= o_ok & i_ok;
        kind_q <= llbg_pkg::KIND_WGRAD;
      end
    end
  end

  // counters
  logic [IW-1:0] c_q, c_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          c_last;
  assign c_last = (CW'(c_q) == nc - CW'(1));

  // output register
  logic            out_valid_q, out_free, out_load;
  logic [1:0]      out_kind_q, out_kind_d;
  logic [15:0]     out_idx_q, out_idx_d;
  logic [ACC-1:0]  out_val_q, out_val_d;
  logic            out_last_q, out_last_d;
  assign out_free = !out_valid_q || m_tready;

  // memory ports
  logic [15:0]    w_rdata, x_rdata;
  logic [ACC-1:0] ig_rdata, wg_rdata, bg_rdata;
  logic           ig_valid_q [MAX_IN_CH];
  logic           iss;
  logic           wg_re, bg_re, bg_we, clr_we;
  logic [AW-1:0]  wg_raddr;
  logic [ACC-1:0] bg_wdata;

  // gradient pipeline
  logic                  v1_q, v2_q;
  logic [IW-1:0]         c1_q, c2_q;
  logic signed [31:0]    pw2_q, pi2_q;
  logic signed [ACC-1:0] ig2_q, wg2_q;
  logic                  ig_clr;

  // next state and controls
  always_comb begin
    state_d    = state_q;
    c_d        = c_q;
    clr_d      = clr_q;
    iss        = 1'b0;
    wg_re      = 1'b0;
    bg_re      = 1'b0;
    bg_we      = 1'b0;
    clr_we     = 1'b0;
    wg_raddr   = base_q + AW'(c_q);
    bg_wdata   = sat_add(bg_rdata, ACC'($signed({v_q, 8'd0})));
    out_load   = 1'b0;
    ig_clr     = 1'b0;
    out_kind_d = out_kind_q;
    out_idx_d  = out_idx_q;
    out_val_d  = out_val_q;
    out_last_d = out_last_q;
    case (state_q)
      llbg_pkg::ST_CLEAR: begin
        clr_we = 1'b1;
        clr_d  = clr_q + AW'(1);
        if (clr_q == AW'(WDEPTH - 1)) begin
          state_d = llbg_pkg::ST_IDLE;
        end
      end
      llbg_pkg::ST_IDLE: begin
        c_d   = '0;
        clr_d = '0;
        if (accept) begin
          case (in_cmd)
            llbg_pkg::CMD_GRAD: begin
              if (o_ok) begin
                if (bias_en_q) state_d = llbg_pkg::ST_B_RD;
                else if (nc != '0) state_d = llbg_pkg::ST_GRAD;
              end
            end
            llbg_pkg::CMD_ROW_END: begin
              if (nc != '0) state_d = llbg_pkg::ST_ROW_RD;
            end
            llbg_pkg::CMD_RD_WG, llbg_pkg::CMD_RD_BG: state_d = llbg_pkg::ST_RD_ISSUE;
            llbg_pkg::CMD_CLEAR: state_d = llbg_pkg::ST_CLEAR;
            default: ;
          endcase
        end
      end
      llbg_pkg::ST_B_RD: begin
        bg_re   = 1'b1;
        state_d = llbg_pkg::ST_B_WR;
      end
      llbg_pkg::ST_B_WR: begin
        bg_we   = 1'b1;
        state_d = (nc != '0) ? llbg_pkg::ST_GRAD : llbg_pkg::ST_IDLE;
      end
      llbg_pkg::ST_GRAD: begin
        iss   = 1'b1;
        wg_re = 1'b1;
        c_d   = c_q + IW'(1);
        if (c_last) state_d = llbg_pkg::ST_DRAIN;
      end
      llbg_pkg::ST_DRAIN: begin
        if (!v1_q && !v2_q) state_d = llbg_pkg::ST_IDLE;
      end
      llbg_pkg::ST_ROW_RD: begin
        state_d = llbg_pkg::ST_ROW_WAIT;
      end
      llbg_pkg::ST_ROW_WAIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          ig_clr     = 1'b1;
          out_kind_d = llbg_pkg::KIND_IGRAD;
          out_idx_d  = 16'(c_q);
          out_val_d  = ig_valid_q[c_q] ? ig_rdata : '0;
          out_last_d = c_last;
          c_d        = c_q + IW'(1);
          state_d    = c_last ? llbg_pkg::ST_IDLE : llbg_pkg::ST_ROW_RD;
        end
      end
      llbg_pkg::ST_RD_ISSUE: begin
        wg_raddr = waddr_q;
        wg_re    = ok_q && (kind_q == llbg_pkg::KIND_WGRAD);
        bg_re    = ok_q && (kind_q == llbg_pkg::KIND_BGRAD);
        state_d  = llbg_pkg::ST_RD_WAIT;
      end
      llbg_pkg::ST_RD_WAIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = kind_q;
          out_idx_d  = idx_q;
          out_last_d = 1'b1;
          if (!ok_q) out_val_d = '0;
          else out_val_d = (kind_q == llbg_pkg::KIND_WGRAD) ? wg_rdata : bg_rdata;
          state_d    = llbg_pkg::ST_IDLE;
        end
      end
      default: state_d = llbg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= llbg_pkg::ST_CLEAR;
      c_q     <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      c_q     <= c_d;
      clr_q   <= clr_d;
    end
  end

  // result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    out_kind_q <= out_kind_d;
    out_idx_q  <= out_idx_d;
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = {out_val_q, out_idx_q};
  assign m_tuser  = out_kind_q;
  assign m_tlast  = out_last_q;

  // MAC pipeline: read, multiply, accumulate and write back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= iss;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c1_q  <= c_q;
    c2_q  <= c1_q;
    pw2_q <= $signed(w_rdata) * v_q;
    pi2_q <= $signed(x_rdata) * v_q;
    ig2_q <= ig_valid_q[c1_q] ? ig_rdata : '0;
    wg2_q <= wg_rdata;
  end

  // input-gradient row valid bits: zero until accumulated, cleared on emit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_IN_CH; k++) ig_valid_q[k] <= 1'b0;
    end else begin
      if (v2_q) ig_valid_q[c2_q] <= 1'b1;
      if (ig_clr) ig_valid_q[c_q] <= 1'b0;
    end
  end

  logic           w_we, x_we;
  logic [ACC-1:0] ig_wdata, wg_wdata;
  assign w_we     = accept && (in_cmd == llbg_pkg::CMD_LOAD_W) && o_ok && i_ok;
  assign x_we     = accept && (in_cmd == llbg_pkg::CMD_LOAD_X) && i_ok;
  assign ig_wdata = sat_add(ig2_q, ACC'(pw2_q));
  assign wg_wdata = clr_we ? '0 : sat_add(wg2_q, ACC'(pi2_q));

  llbg_ram #(.WIDTH(16), .DEPTH(WDEPTH)) u_weight (
    .clk_i  (clk_i),
    .we_i   (w_we),
    .waddr_i(AW'(int'(in_o) * MAX_IN_CH + int'(in_i))),
    .wdata_i(in_v),
    .re_i   (iss),
    .raddr_i(base_q + AW'(c_q)),
    .rdata_o(w_rdata)
  );

  llbg_ram #(.WIDTH(16), .DEPTH(MAX_IN_CH)) u_input (
    .clk_i  (clk_i),
    .we_i   (x_we),
    .waddr_i(in_i[IW-1:0]),
    .wdata_i(in_v),
    .re_i   (iss),
    .raddr_i(c_q),
    .rdata_o(x_rdata)
  );

  llbg_ram #(.WIDTH(ACC), .DEPTH(MAX_IN_CH)) u_igrad (
    .clk_i  (clk_i),
    .we_i   (v2_q),
    .waddr_i(c2_q),
    .wdata_i(ig_wdata),
    .re_i   (iss || (state_q == llbg_pkg::ST_ROW_RD)),
    .raddr_i(c_q),
    .rdata_o(ig_rdata)
  );

  llbg_ram #(.WIDTH(ACC), .DEPTH(WDEPTH)) u_wgrad (
    .clk_i  (clk_i),
    .we_i   (v2_q || clr_we),
    .waddr_i(clr_we ? clr_q : base_q + AW'(c2_q)),
    .wdata_i(wg_wdata),
    .re_i   (wg_re),
    .raddr_i(wg_raddr),
    .rdata_o(wg_rdata)
  );

  llbg_ram #(.WIDTH(ACC), .DEPTH(MAX_OUT_CH)) u_bgrad (
    .clk_i  (clk_i),
    .we_i   (bg_we || (clr_we && (int'(clr_q) < MAX_OUT_CH))),
    .waddr_i(clr_we ? clr_q[OW-1:0] : oaddr_q),
    .wdata_i(clr_we ? '0 : bg_wdata),
    .re_i   (bg_re),
    .raddr_i(oaddr_q),
    .rdata_o(bg_rdata)
  );

  // checks
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || m_tready))
    else $error("result register overwritten");

  a_pipe_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> $past(v1_q))
    else $error("MAC pipeline out of step");

  a_no_clear_during_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_we |-> (!v1_q && !v2_q))
    else $error("clearing sweep overlaps gradient write-back");

  a_drain_before_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == llbg_pkg::ST_IDLE) |-> !v2_q)
    else $error("accepting while write-back pending");

endmodule

[tb/testbench.sv]
// Testbench for linear_layer_backward_gradients: directed and random command streams,
// checked word by word against an in-bench gradient predictor.
// Depends on llbg_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int NIN  = 64;
  localparam int NOUT = 256;
  localparam logic [47:0] AMAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] AMIN = 48'h8000_0000_0000;

  typedef struct packed {
    llbg_pkg::kind_e kind;
    logic [15:0]     index;
    logic [47:0]     value;
    logic            last;
  } grad_word_t;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [63:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  linear_layer_backward_gradients DUT (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic signed [15:0] w_mem [NOUT*NIN];
  logic signed [15:0] x_row [NIN];
  logic signed [47:0] ig_row [NIN];
  logic signed [47:0] wg_mem [NOUT*NIN];
  logic signed [47:0] bg_mem [NOUT];
  int unsigned        n_in = 64, n_out = 256;
  bit                 bias_on = 1;

  grad_word_t expected_q[$];
  int errors = 0;
  int words_sent = 0, words_seen = 0;
  bit hold_off = 0;

  function automatic logic signed [47:0] sat48(logic signed [47:0] a, logic signed [47:0] b);
    logic signed [48:0] s;
    s = {a[47], a} + {b[47], b};
    if (s > $signed({1'b0, AMAX})) return AMAX;
    if (s < $signed({1'b1, AMIN})) return AMIN;
    return s[47:0];
  endfunction

  function automatic void push_word(llbg_pkg::kind_e k, int idx, logic [47:0] v, bit l);
    grad_word_t g;
    g.kind = k; g.index = idx[15:0]; g.value = v; g.last = l;
    expected_q.push_back(g);
  endfunction

  // Update predicted stores and queue the words the command yields
  function automatic void predict_grads(llbg_pkg::cmd_e cmd, int o, int i,
                                        logic signed [15:0] v);
    int nc, noc, wi;
    logic signed [47:0] pw, px;
    nc = n_in < NIN ? n_in : NIN;
    noc = n_out < NOUT ? n_out : NOUT;
    wi = o * NIN + i;
    case (cmd)
      llbg_pkg::CMD_LOAD_W: if (o < noc && i < nc) w_mem[wi] = v;
      llbg_pkg::CMD_LOAD_X: if (i < nc) x_row[i] = v;
      llbg_pkg::CMD_GRAD: if (o < noc) begin
        for (int c = 0; c < nc; c++) begin
          pw = w_mem[o*NIN+c] * v;
          px = x_row[c] * v;
          ig_row[c] = sat48(ig_row[c], pw);
          wg_mem[o*NIN+c] = sat48(wg_mem[o*NIN+c], px);
        end
        if (bias_on) bg_mem[o] = sat48(bg_mem[o], 48'(v) <<< 8);
      end
      llbg_pkg::CMD_ROW_END: for (int c = 0; c < nc; c++) begin
        push_word(llbg_pkg::KIND_IGRAD, c, ig_row[c], c + 1 == nc);
        ig_row[c] = 0;
      end
      llbg_pkg::CMD_RD_WG: push_word(llbg_pkg::KIND_WGRAD, wi,
                                     (o < noc && i < nc) ? wg_mem[wi] : 48'd0, 1);
      llbg_pkg::CMD_RD_BG: push_word(llbg_pkg::KIND_BGRAD, o, o < noc ? bg_mem[o] : 48'd0, 1);
      llbg_pkg::CMD_CLEAR: begin
        foreach (wg_mem[k]) wg_mem[k] = 0;
        foreach (bg_mem[k]) bg_mem[k] = 0;
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h want %0h (word %0d)", what, got, want, words_seen);
    errors++;
  endtask

  // Send one command word; predict at acceptance, then drop valid before returning
  task automatic send_word(llbg_pkg::cmd_e cmd, int o, int i, logic [15:0] v);
    s_tvalid <= 1;
    s_tuser  <= cmd;
    s_tdata  <= {v, i[5:0], o[9:0]};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    predict_grads(cmd, o & 'h3FF, i & 'h3F, v);
    words_sent++;
    s_tvalid <= 0;
    @(posedge clk_i);
  endtask

  task automatic random_gap();
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (NIN + 20) @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      llbg_pkg::REG_IN_USE:  n_in = val[6:0];
      llbg_pkg::REG_OUT_USE: n_out = val[10:0];
      llbg_pkg::REG_BIAS_EN: bias_on = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_shape(int ni, int no, bit be);
    wait_drained();
    write_reg(llbg_pkg::REG_IN_USE, ni);
    write_reg(llbg_pkg::REG_OUT_USE, no);
    write_reg(llbg_pkg::REG_BIAS_EN, 32'(be));
  endtask

  // Load all in-use weights and the input row so no unwritten entry is read
  task automatic load_operands(bit extreme);
    int nc, noc;
    nc = n_in < NIN ? n_in : NIN;
    noc = n_out < NOUT ? n_out : NOUT;
    for (int o = 0; o < noc; o++)
      for (int c = 0; c < nc; c++) begin
        send_word(llbg_pkg::CMD_LOAD_W, o, c, extreme ? ((o + c) % 2 ? 16'h8000 : 16'h7FFF)
                                                      : 16'($urandom));
        random_gap();
      end
    for (int c = 0; c < nc; c++) begin
      send_word(llbg_pkg::CMD_LOAD_X, 0, c, extreme ? 16'h8000 : 16'($urandom));
      random_gap();
    end
  endtask

  // Result receiver: stall pattern plus long hold-off on request
  always @(posedge clk_i) begin
    m_tready <= !hold_off && ($urandom_range(0, 4) != 0 || $urandom_range(0, 1));
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      grad_word_t g;
      words_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected word", m_tdata, 0);
      end else begin
        g = expected_q.pop_front();
        if (m_tuser != g.kind) report_mismatch("kind", 64'(m_tuser), 64'(g.kind));
        if (m_tdata[15:0] != g.index)
          report_mismatch("index", 64'(m_tdata[15:0]), 64'(g.index));
        if (m_tdata[63:16] != g.value)
          report_mismatch("value", 64'(m_tdata[63:16]), 64'(g.value));
        if (m_tlast != g.last) report_mismatch("last", 64'(m_tlast), 64'(g.last));
      end
    end
  end

  task automatic test_extremes();
    set_shape(4, 2, 1);
    load_operands(1);
    for (int k = 0; k < 3; k++) send_word(llbg_pkg::CMD_GRAD, k % 2, 0, 16'h8000);
    send_word(llbg_pkg::CMD_GRAD, 1, 0, 16'h7FFF);
    send_word(llbg_pkg::CMD_GRAD, 5, 0, 16'h7FFF);       // out-of-range channel ignored
    send_word(llbg_pkg::CMD_ROW_END, 0, 0, 0);
    send_word(llbg_pkg::CMD_RD_WG, 1, 3, 0);
    send_word(llbg_pkg::CMD_RD_WG, 1023, 63, 0);         // readback out of range
    send_word(llbg_pkg::CMD_RD_BG, 0, 0, 0);
    send_word(llbg_pkg::CMD_RD_BG, 1023, 0, 0);
    send_word(llbg_pkg::CMD_NONE, 3, 3, 16'hFFFF);       // unused command
    send_word(llbg_pkg::CMD_LOAD_W, 9, 9, 16'h1234);     // ignored load
    send_word(llbg_pkg::CMD_CLEAR, 0, 0, 0);
    send_word(llbg_pkg::CMD_RD_BG, 1, 0, 0);
    send_word(llbg_pkg::CMD_RD_WG, 0, 0, 0);
  endtask

  task automatic test_zero_regs();
    set_shape(0, 0, 0);
    send_word(llbg_pkg::CMD_ROW_END, 0, 0, 0);
    send_word(llbg_pkg::CMD_GRAD, 0, 0, 16'h0100);
    send_word(llbg_pkg::CMD_RD_BG, 0, 0, 0);
    set_shape(127, 2047, 1);                             // clamps to block maxima
    send_word(llbg_pkg::CMD_ROW_END, 0, 0, 0);
  endtask

  // Well-formed rows with random content, plus some noise
  task automatic test_random_rows(int ni, int no, bit be, int rows);
    set_shape(ni, no, be);
    load_operands(0);
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < ni; c++) if ($urandom_range(0, 1))
        send_word(llbg_pkg::CMD_LOAD_X, 0, c, 16'($urandom));
      repeat ($urandom_range(1, 4)) begin
        send_word(llbg_pkg::CMD_GRAD, $urandom_range(0, no), $urandom, 16'($urandom));
        random_gap();
      end
      if ($urandom_range(0, 3) == 0) send_word(llbg_pkg::CMD_RD_WG, $urandom_range(0, no),
                                               $urandom_range(0, ni), 0);
      if ($urandom_range(0, 3) == 0)
        send_word(llbg_pkg::CMD_RD_BG, $urandom_range(0, 1023), 0, 0);
      if ($urandom_range(0, 9) == 0)
        send_word(llbg_pkg::cmd_e'($urandom_range(0, 7)), $urandom, $urandom,
                  16'($urandom));
      send_word(llbg_pkg::CMD_ROW_END, 0, 0, 0);
      random_gap();
    end
  endtask

  // Hold the receiver off while row ends pile up
  task automatic test_backpressure();
    set_shape(8, 2, 1);
    load_operands(0);
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk_i);
        hold_off = 0;
      end
      repeat (4) begin
        send_word(llbg_pkg::CMD_GRAD, 1, 0, 16'($urandom));
        send_word(llbg_pkg::CMD_ROW_END, 0, 0, 0);
      end
    join
    wait_drained();
  endtask

  initial begin
    foreach (ig_row[k]) ig_row[k] = 0;
    foreach (wg_mem[k]) wg_mem[k] = 0;
    foreach (bg_mem[k]) bg_mem[k] = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    test_extremes();
    test_zero_regs();
    test_random_rows(3, 3, 1, 6);
    test_random_rows(1, 1, 0, 4);
    test_backpressure();
    wait_drained();
    $display("Covered %0d input words, %0d result words, several channel/bias settings.",
             words_sent, words_seen);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end
endmodule
